// File: design/typed_frame_parser_sum_check_assert.svh
// Assertion macros used by the checker module.
`ifndef TYPED_FRAME_PARSER_SUM_CHECK_ASSERT_SVH
`define TYPED_FRAME_PARSER_SUM_CHECK_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define TFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define TFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tfp_pkg.sv
package tfp_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int TYPE_W     = 3;
    localparam int MAX_TYPES  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BYTE_W * MAX_TYPES;

    // Register index of the packed payload length table
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTHS = CFG_IDX_W'(MAX_TYPES);

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_HEADER  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BAD     = 3'd4
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t              event_kind;
        logic [TYPE_W-1:0]     frame_type;
        logic [BYTE_W-1:0]     byte_index;
        logic [BYTE_W-1:0]     payload_byte;
    } result_t;

endpackage

// File: design/tfp_cfg_regs.sv
module tfp_cfg_regs #(
    parameter int NUM_TYPES = 6
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [tfp_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [tfp_pkg::CFG_DATA_W-1:0]            cfg_wr_data,
    output logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] type_code,
    output logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] payload_len
);

    logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] code_reg;
    logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] code_next;
    logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] len_reg;
    logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] len_next;

    // Write decode; indexes with no register behind them are dropped
    always_comb
    begin
        code_next = code_reg;
        len_next  = len_reg;
        if (cfg_wr_en)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                if (cfg_index == tfp_pkg::CFG_IDX_W'(i))
                begin
                    code_next[i] = cfg_wr_data[tfp_pkg::BYTE_W-1:0];
                end
            end
            if (cfg_index == tfp_pkg::CFG_IDX_LENGTHS)
            begin
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    len_next[i] = cfg_wr_data[tfp_pkg::BYTE_W*i +: tfp_pkg::BYTE_W];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            code_reg <= code_next;
            len_reg  <= len_next;
        end
    end

    assign type_code   = code_reg;
    assign payload_len = len_reg;

endmodule

// File: design/tfp_frame_core.sv
module tfp_frame_core #(
    parameter int NUM_TYPES = 6
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      accept,
    input  logic [tfp_pkg::BYTE_W-1:0]                rx_byte,
    input  logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] type_code,
    input  logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] payload_len,
    output tfp_pkg::result_t                          result
);

    // Frame state
    logic                        in_frame_reg;
    logic                        in_frame_next;
    logic [tfp_pkg::TYPE_W-1:0]  cur_type_reg;
    logic [tfp_pkg::TYPE_W-1:0]  cur_type_next;
    logic [tfp_pkg::BYTE_W-1:0]  exp_len_reg;
    logic [tfp_pkg::BYTE_W-1:0]  exp_len_next;
    logic [tfp_pkg::BYTE_W-1:0]  pay_cnt_reg;
    logic [tfp_pkg::BYTE_W-1:0]  pay_cnt_next;
    logic [tfp_pkg::BYTE_W-1:0]  sum_reg;
    logic [tfp_pkg::BYTE_W-1:0]  sum_next;

    // Start byte match
    logic                        hit;
    logic [tfp_pkg::TYPE_W-1:0]  hit_type;
    logic [tfp_pkg::BYTE_W-1:0]  hit_len;

    // Compare against every enabled code; scanning downward lets the lowest index win
    always_comb
    begin
        hit      = 1'b0;
        hit_type = '0;
        hit_len  = '0;
        for (int i = NUM_TYPES - 1; i >= 0; i--)
        begin
            if ((type_code[i] != '0) && (type_code[i] == rx_byte))
            begin
                hit      = 1'b1;
                hit_type = tfp_pkg::TYPE_W'(i);
                hit_len  = payload_len[i];
            end
        end
    end

    // Next state and result for the byte on the input
    always_comb
    begin
        in_frame_next = in_frame_reg;
        cur_type_next = cur_type_reg;
        exp_len_next  = exp_len_reg;
        pay_cnt_next  = pay_cnt_reg;
        sum_next      = sum_reg;

        result.event_kind   = tfp_pkg::EV_IGNORED;
        result.frame_type   = '0;
        result.byte_index   = '0;
        result.payload_byte = '0;

        if (!in_frame_reg)
        begin
            // Hunting: only a matching start byte opens a frame
            if (hit)
            begin
                in_frame_next     = 1'b1;
                cur_type_next     = hit_type;
                exp_len_next      = hit_len;
                pay_cnt_next      = '0;
                sum_next          = rx_byte;
                result.event_kind = tfp_pkg::EV_HEADER;
                result.frame_type = hit_type;
            end
        end
        else if (pay_cnt_reg < exp_len_reg)
        begin
            result.event_kind   = tfp_pkg::EV_PAYLOAD;
            result.frame_type   = cur_type_reg;
            result.byte_index   = pay_cnt_reg;
            result.payload_byte = rx_byte;
            sum_next            = sum_reg + rx_byte;
            pay_cnt_next        = pay_cnt_reg + 8'd1;
        end
        else
        begin
            // Checksum byte closes the frame
            result.event_kind = (sum_reg == rx_byte) ? tfp_pkg::EV_GOOD : tfp_pkg::EV_BAD;
            result.frame_type = cur_type_reg;
            in_frame_next     = 1'b0;
            cur_type_next     = '0;
            exp_len_next      = '0;
            pay_cnt_next      = '0;
            sum_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            cur_type_reg <= '0;
            exp_len_reg  <= '0;
            pay_cnt_reg  <= '0;
            sum_reg      <= '0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            cur_type_reg <= cur_type_next;
            exp_len_reg  <= exp_len_next;
            pay_cnt_reg  <= pay_cnt_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

// File: design/tfp_out_skid.sv
module tfp_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tfp_pkg::result_t push_data,
    input  logic             out_stall,
    output logic             out_valid,
    output tfp_pkg::result_t out_data,
    output logic             full
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    tfp_pkg::result_t out_data_reg;
    tfp_pkg::result_t out_data_next;
    tfp_pkg::result_t skid_data_reg;
    tfp_pkg::result_t skid_data_next;
    logic             take;

    assign take = out_valid_reg && !out_stall;

    // Output register plus one skid entry; push only happens while the skid is empty
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg)
        begin
            if (push)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            // Output held by the receiver: park the new result
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

// File: design/typed_frame_parser_sum_check.sv
// Typed frame parser with an 8-bit additive checksum.
// Input channel: one received byte (rx_byte) per transaction, in_valid / in_stall.
// Output channel: one event per input byte (event_kind, frame_type, byte_index,
//   payload_byte), out_valid / out_stall. Events come out in input order.
// Configuration: cfg_wr_en / cfg_index / cfg_wr_data; indexes 0..5 set the
//   start codes (zero disables a type), index 6 the packed payload lengths.
//   Write only while no event is pending.
// Timing: an accepted byte's event is registered in the output or skid register.
// Throughput: one byte per cycle unless stalled; start-code compare, checksum add
//   and payload counter step all fit between the state and the output register.
// Reset: all codes and lengths clear, so every type is disabled and the parser
//   hunts; no event is pending.
// Stall: the output register holds under out_stall; one more event parks in a
//   skid entry, and in_stall rises only once that entry is occupied.
module typed_frame_parser_sum_check #(
    parameter int NUM_TYPES = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [tfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfp_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tfp_pkg::BYTE_W-1:0]         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         event_kind,
    output logic [tfp_pkg::TYPE_W-1:0]         frame_type,
    output logic [tfp_pkg::BYTE_W-1:0]         byte_index,
    output logic [tfp_pkg::BYTE_W-1:0]         payload_byte
);

    logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] type_code;
    logic [NUM_TYPES-1:0][tfp_pkg::BYTE_W-1:0] payload_len;
    logic                                      accept;
    logic                                      skid_full;
    tfp_pkg::result_t                          core_result;
    tfp_pkg::result_t                          out_data;

    assign in_stall = skid_full;
    assign accept   = in_valid && !skid_full;

    tfp_cfg_regs #(
        .NUM_TYPES   (NUM_TYPES)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .type_code   (type_code),
        .payload_len (payload_len)
    );

    tfp_frame_core #(
        .NUM_TYPES   (NUM_TYPES)
    ) u_frame_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .type_code   (type_code),
        .payload_len (payload_len),
        .result      (core_result)
    );

    tfp_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (skid_full)
    );

    assign event_kind   = out_data.event_kind;
    assign frame_type   = out_data.frame_type;
    assign byte_index   = out_data.byte_index;
    assign payload_byte = out_data.payload_byte;

endmodule

// File: design/tfp_checker.sv
`include "typed_frame_parser_sum_check_assert.svh"

module tfp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [2:0]                     event_kind,
    input logic [tfp_pkg::TYPE_W-1:0]     frame_type,
    input logic [tfp_pkg::BYTE_W-1:0]     byte_index,
    input logic [tfp_pkg::BYTE_W-1:0]     payload_byte
);

    // A held output transaction keeps its contents
    `TFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(frame_type) && $stable(byte_index) && $stable(payload_byte), "output changed while stalled")

    // Every accepted input transaction leaves an event at the output
    `TFP_ASSERT_NEXT(a_accept_out, in_valid && !in_stall, out_valid, "accepted byte gave no event")

    // Back-pressure on the input only while an event waits at the output
    `TFP_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid, "in_stall without a pending output")

    // Input stall begins only after the receiver held the output
    `TFP_ASSERT_NOW(a_stall_rise, $rose(in_stall), $past(out_valid && out_stall), "in_stall rose without output stall")

    // Only payload events carry an index and a byte
    `TFP_ASSERT_NOW(a_non_payload_zero, out_valid && (event_kind != tfp_pkg::EV_PAYLOAD), (byte_index == '0) && (payload_byte == '0), "non-payload event carries data")

endmodule

bind typed_frame_parser_sum_check tfp_checker u_tfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .frame_type   (frame_type),
    .byte_index   (byte_index),
    .payload_byte (payload_byte)
);

// File: tb/typed_frame_parser_sum_check_test.sv
module typed_frame_parser_sum_check_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tfp_pkg::*;

    localparam int PARSER_TYPES = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int HOLD_CYCLES  = 80;     // long receiver hold-off for the pressure test
    localparam int DRAIN_SLACK  = 4;      // cycles after the last event
    localparam int RUN_LIMIT_NS = 400_000;
    localparam int MAX_PRINTS   = 50;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             event_kind;
    logic [TYPE_W-1:0]      frame_type;
    logic [BYTE_W-1:0]      byte_index;
    logic [BYTE_W-1:0]      payload_byte;

    // Parser shadow: configuration and frame state
    logic [7:0]  start_codes [PARSER_TYPES];
    logic [47:0] length_table;
    logic        frame_open;
    logic [2:0]  open_type;
    logic [7:0]  open_len;
    logic [7:0]  open_count;
    logic [7:0]  open_sum;

    result_t pending_events [$];
    result_t oldest;

    bit send_idles;
    bit recv_idles;
    bit hold_request;

    int error_count;
    int bytes_accepted;
    int bytes_framed;
    int events_checked;
    int input_stall_cycles;
    int settings_loaded;
    int kind_count [5];

    typed_frame_parser_sum_check #(
        .NUM_TYPES(PARSER_TYPES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .frame_type(frame_type),
        .byte_index(byte_index),
        .payload_byte(payload_byte)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Expected event for one accepted byte; advances the shadow frame state
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        logic    hit;
        r   = '0;
        hit = 1'b0;
        if (!frame_open)
        begin
            r.event_kind = EV_IGNORED;
            // lowest matching type wins, zero codes never match
            for (int i = 0; i < PARSER_TYPES; i++)
            begin
                if (!hit && start_codes[i] != 8'h00 && start_codes[i] == b)
                begin
                    hit          = 1'b1;
                    frame_open   = 1'b1;
                    open_type    = 3'(i);
                    open_len     = length_table[8*i +: 8];
                    open_count   = 8'h00;
                    open_sum     = b;
                    r.event_kind = EV_HEADER;
                    r.frame_type = 3'(i);
                end
            end
        end
        else if (open_count < open_len)
        begin
            r.event_kind   = EV_PAYLOAD;
            r.frame_type   = open_type;
            r.byte_index   = open_count;
            r.payload_byte = b;
            open_sum       = open_sum + b;
            open_count     = open_count + 8'd1;
        end
        else
        begin
            // checksum byte closes the frame
            r.event_kind = (open_sum == b) ? EV_GOOD : EV_BAD;
            r.frame_type = open_type;
            frame_open   = 1'b0;
            open_type    = 3'd0;
            open_len     = 8'h00;
            open_count   = 8'h00;
            open_sum     = 8'h00;
        end
        return r;
    endfunction

    // One input transaction, with an optional idle burst in front
    task automatic offer_byte(input logic [7:0] b);
        result_t want;
        if (send_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = parse_byte(b);
        pending_events.push_back(want);
        bytes_accepted++;
        if (want.event_kind != EV_IGNORED)
        begin
            bytes_framed++;
        end
    endtask

    // Stop offering and let every expected event come out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx < CFG_IDX_LENGTHS)
        begin
            start_codes[idx] = data[7:0];
        end
        else if (idx == CFG_IDX_LENGTHS)
        begin
            length_table = data;
        end
    endtask

    // Load all six start codes and the length table; upper bits of code writes are junk
    task automatic program_table(input logic [47:0] codes, input logic [47:0] lens);
        wait_quiet();
        for (int i = 0; i < PARSER_TYPES; i++)
        begin
            write_reg(CFG_IDX_W'(i), {8'($urandom), 32'($urandom), codes[8*i +: 8]});
        end
        write_reg(CFG_IDX_LENGTHS, lens);
        settings_loaded++;
    endtask

    task automatic program_random_table(input bit longest);
        logic [47:0] codes;
        logic [47:0] lens;
        for (int i = 0; i < PARSER_TYPES; i++)
        begin
            codes[8*i +: 8] = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            if (i > 0 && $urandom_range(0, 5) == 0)
            begin
                codes[8*i +: 8] = codes[8*(i-1) +: 8];
            end
            if (longest)
            begin
                lens[8*i +: 8] = 8'hFF;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                lens[8*i +: 8] = 8'($urandom_range(8, 40));
            end
            else
            begin
                lens[8*i +: 8] = 8'($urandom_range(0, 7));
            end
        end
        if (codes == '0)
        begin
            codes[7:0] = 8'($urandom_range(1, 255));
        end
        program_table(codes, lens);
    endtask

    // Random byte biased toward the extremes
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
        begin
            return 8'h00;
        end
        if (roll == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    // Enabled type that its own code actually selects (first match)
    function automatic int pick_type();
        int j;
        int t;
        do
        begin
            j = $urandom_range(0, PARSER_TYPES - 1);
        end
        while (start_codes[j] == 8'h00);
        t = 0;
        while (start_codes[t] != start_codes[j]) t++;
        return t;
    endfunction

    // Well-formed frame, optionally with a bad checksum or cut short
    task automatic send_frame(input int t, input bit corrupt, input bit truncate);
        logic [7:0] sum;
        logic [7:0] b;
        int         len;
        int         cut;
        len = int'(length_table[8*t +: 8]);
        cut = truncate ? $urandom_range(0, len) : len + 1;
        sum = start_codes[t];
        offer_byte(start_codes[t]);
        for (int k = 0; k < len; k++)
        begin
            if (k == cut)
            begin
                return;
            end
            b   = pick_byte();
            sum = sum + b;
            offer_byte(b);
        end
        if (truncate)
        begin
            return;
        end
        offer_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    endtask

    // Runs until the given number of bytes landed inside frames; ignored bytes do not count
    task automatic run_random_phase(input int budget);
        int start;
        int choice;
        start = bytes_framed;
        while (bytes_framed - start < budget)
        begin
            if (frame_open)
            begin
                offer_byte(pick_byte());
            end
            else
            begin
                choice = $urandom_range(0, 9);
                if (choice < 8)
                begin
                    send_frame(pick_type(), $urandom_range(0, 3) == 0, 1'b0);
                end
                else if (choice == 8)
                begin
                    send_frame(pick_type(), 1'b0, 1'b1);
                end
                else
                begin
                    offer_byte(8'($urandom));
                end
            end
        end
    endtask

    // After reset every type is disabled, so everything is dropped
    task automatic test_reset_hunting();
        offer_byte(8'h00);
        offer_byte(8'hFF);
        offer_byte(8'h55);
        offer_byte(8'hAA);
    endtask

    task automatic test_directed_frames();
        // type 4 repeats type 0's code, type 3 is disabled
        program_table({8'h80, 8'hA5, 8'h00, 8'hFF, 8'h01, 8'hA5},
                      {8'd1, 8'd3, 8'd9, 8'd1, 8'd0, 8'd2});
        offer_byte(8'h00);                 // zero code never matches
        offer_byte(8'h7E);
        // duplicate code picks type 0; the sum wraps
        offer_byte(8'hA5);
        offer_byte(8'hFF);
        offer_byte(8'hFF);
        offer_byte(8'hA3);
        // empty payload: checksum equals the code
        offer_byte(8'h01);
        offer_byte(8'h01);
        // bad checksum
        offer_byte(8'hFF);
        offer_byte(8'h00);
        offer_byte(8'h00);
        // highest type index
        offer_byte(8'h80);
        offer_byte(8'h7F);
        offer_byte(8'hFF);
        // unused register index must change nothing
        wait_quiet();
        write_reg(CFG_IDX_UNUSED, '1);
        offer_byte(8'hA5);
        offer_byte(8'h12);
        offer_byte(8'h34);
        offer_byte(8'h00);
    endtask

    // Receiver holds off while the sender keeps offering, filling the block
    task automatic test_output_backpressure();
        wait_quiet();
        send_idles   = 1'b0;
        hold_request = 1'b1;
        repeat (5) send_frame(pick_type(), 1'b0, 1'b0);
        send_idles = 1'b1;
    endtask

    task automatic test_random_traffic();
        // all codes alike with empty payloads
        program_table({6{8'hFF}}, 48'h0);
        run_random_phase(120);
        // longest payloads everywhere
        program_random_table(1'b1);
        run_random_phase(300);
        for (int p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                send_idles = 1'b0;
                recv_idles = 1'b0;
            end
            program_random_table(1'b0);
            run_random_phase(140);
        end
    endtask

    // Receiver side: random stall bursts and the long hold-off
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (recv_idles && rst_n && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each output transaction with the oldest expected event
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
            begin
                input_stall_cycles++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    flag_error($sformatf("event kind %0d with nothing expected", event_kind));
                end
                else
                begin
                    oldest = pending_events.pop_front();
                    events_checked++;
                    if (event_kind < 3'd5)
                    begin
                        kind_count[event_kind]++;
                    end
                    if (event_kind !== oldest.event_kind)
                    begin
                        flag_error($sformatf("event_kind %0d, expected %0d",
                                             event_kind, oldest.event_kind));
                    end
                    if (frame_type !== oldest.frame_type)
                    begin
                        flag_error($sformatf("frame_type %0d, expected %0d",
                                             frame_type, oldest.frame_type));
                    end
                    if (byte_index !== oldest.byte_index)
                    begin
                        flag_error($sformatf("byte_index %0d, expected %0d",
                                             byte_index, oldest.byte_index));
                    end
                    if (payload_byte !== oldest.payload_byte)
                    begin
                        flag_error($sformatf("payload_byte %02h, expected %02h",
                                             payload_byte, oldest.payload_byte));
                    end
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        length_table = '0;
        frame_open   = 1'b0;
        open_type    = '0;
        open_len     = '0;
        open_count   = '0;
        open_sum     = '0;
        for (int i = 0; i < PARSER_TYPES; i++)
        begin
            start_codes[i] = 8'h00;
        end
        send_idles   = 1'b1;
        recv_idles   = 1'b1;
        hold_request = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_hunting();
        test_directed_frames();
        test_output_backpressure();
        test_random_traffic();

        wait_quiet();
        if (pending_events.size() != 0)
        begin
            flag_error($sformatf("%0d expected events never came out", pending_events.size()));
        end
        $display("Checked %0d events for %0d accepted bytes: %0d ignored, %0d headers, %0d payload",
                 events_checked, bytes_accepted, kind_count[0], kind_count[1], kind_count[2]);
        $display("Frames good %0d, bad %0d over %0d register settings; input stalled %0d cycles",
                 kind_count[3], kind_count[4], settings_loaded, input_stall_cycles);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/tfp_pkg.sv
design/tfp_cfg_regs.sv
design/tfp_frame_core.sv
design/tfp_out_skid.sv
design/typed_frame_parser_sum_check.sv
design/tfp_checker.sv
tb/typed_frame_parser_sum_check_test.sv
